FILE: sv/prim_mst_total_weight_top_assert.svh
// ----------------------------------------------------------------------------
// prim_mst_total_weight_top_assert.svh
// Assertion macros for the spanning tree block.
// ----------------------------------------------------------------------------
`ifndef PRIM_MST_TOTAL_WEIGHT_TOP_ASSERT_SVH
`define PRIM_MST_TOTAL_WEIGHT_TOP_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define PMTW_ASSERT_NOW(label, clk_i, rst_i, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (rst_i) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define PMTW_ASSERT_NEXT(label, clk_i, rst_i, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (rst_i) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: sv/pmtw_pkg.sv
// ----------------------------------------------------------------------------
// pmtw_pkg
// Shared types and constants for the spanning tree block.
// ----------------------------------------------------------------------------
package pmtw_pkg;

  localparam int MAX_VERTICES_DEF = 64;
  localparam int WEIGHT_BITS_DEF  = 16;
  localparam int VERTEX_BITS      = 6;
  localparam int IN_WEIGHT_BITS   = 16;
  localparam int COUNT_CFG_BITS   = 7;
  localparam int TOTAL_BITS       = 22;
  localparam int S_DATA_BITS      = 32;
  localparam int M_DATA_BITS      = 24;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_LOAD,
    ST_INIT,
    ST_SCAN,
    ST_DRAIN,
    ST_PICK,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic clear_en;
    logic load_en;
    logic run_init;
    logic scan_issue;
    logic pick;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic last_accept;
    logic scan_end;
    logic run_done;
    logic out_free;
  } stat_t;

endpackage

FILE: sv/pmtw_ctrl.sv
// ----------------------------------------------------------------------------
// pmtw_ctrl
// Sequencer: clear sweep, edge loading, Prim rounds and result handoff.
// ----------------------------------------------------------------------------
module pmtw_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  pmtw_pkg::stat_t st,
  output pmtw_pkg::cmd_t  cmd
);
  import pmtw_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      ST_CLEAR: begin
        cmd.clear_en = 1'b1;
        if (st.clear_last) state_next = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.load_en = 1'b1;
        if (st.last_accept) state_next = ST_INIT;
      end
      ST_INIT: begin
        cmd.run_init = 1'b1;
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan_issue = 1'b1;
        if (st.scan_end) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_next = ST_PICK;
      end
      ST_PICK: begin
        cmd.pick = 1'b1;
        state_next = st.run_done ? ST_OUT : ST_SCAN;
      end
      ST_OUT: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_next = ST_CLEAR;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

FILE: sv/pmtw_dp.sv
// ----------------------------------------------------------------------------
// pmtw_dp
// Datapath: triangular weight memory, key memory, round scan and result.
// ----------------------------------------------------------------------------
module pmtw_dp #(
  parameter int MAX_VERTICES = pmtw_pkg::MAX_VERTICES_DEF,
  parameter int WEIGHT_BITS  = pmtw_pkg::WEIGHT_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  pmtw_pkg::cmd_t                       cmd,
  output pmtw_pkg::stat_t                      st,
  input  logic                                 cfg_we,
  input  logic [pmtw_pkg::COUNT_CFG_BITS-1:0]  cfg_wdata,
  input  logic                                 s_tvalid,
  input  logic [pmtw_pkg::S_DATA_BITS-1:0]     s_tdata,
  input  logic                                 s_tlast,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [pmtw_pkg::M_DATA_BITS-1:0]     m_tdata,
  output logic                                 m_tuser
);
  import pmtw_pkg::*;

  localparam int VB = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int NW = $clog2(MAX_VERTICES + 1);
  localparam int KW = WEIGHT_BITS + 1;
  localparam int AW = 2 * VB;
  localparam int SW = ((TOTAL_BITS > KW) ? TOTAL_BITS : KW) + 1;
  localparam logic [KW-1:0] KEY_UNREACHED = '1;
  localparam logic [AW-1:0] ADDR_LAST = '1;

  // configuration
  logic [COUNT_CFG_BITS-1:0] vertex_count;
  logic [NW-1:0]             n_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= COUNT_CFG_BITS'(1);
    end else if (cfg_we) begin
      vertex_count <= cfg_wdata;
    end
  end

  always_comb begin
    if (vertex_count == '0) begin
      n_eff = NW'(1);
    end else if (32'(vertex_count) > 32'(MAX_VERTICES)) begin
      n_eff = NW'(MAX_VERTICES);
    end else begin
      n_eff = NW'(vertex_count);
    end
  end

  // input fields
  logic [VERTEX_BITS-1:0]    first_vertex, second_vertex;
  logic [IN_WEIGHT_BITS-1:0] edge_weight;
  logic                      in_range;
  logic [VB-1:0]             va, vb, vlo, vhi;

  assign first_vertex  = s_tdata[VERTEX_BITS-1:0];
  assign second_vertex = s_tdata[2*VERTEX_BITS-1:VERTEX_BITS];
  assign edge_weight   = s_tdata[2*VERTEX_BITS+IN_WEIGHT_BITS-1:2*VERTEX_BITS];
  assign in_range = (32'(first_vertex) < 32'(n_eff)) && (32'(second_vertex) < 32'(n_eff));
  assign va  = VB'(first_vertex);
  assign vb  = VB'(second_vertex);
  assign vlo = (va < vb) ? va : vb;
  assign vhi = (va < vb) ? vb : va;

  // clear sweep address
  logic [AW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_en) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  // scan state
  logic [NW-1:0]        scan_j;
  logic [VB-1:0]        pick_idx;
  logic                 stg_valid;
  logic [VB-1:0]        stg_j;
  logic [VB-1:0]        jv, plo, phi;

  assign jv  = scan_j[VB-1:0];
  assign plo = (pick_idx < jv) ? pick_idx : jv;
  assign phi = (pick_idx < jv) ? jv : pick_idx;

  // weight memory, upper triangle only
  logic [WEIGHT_BITS-1:0] wmem [2**AW];
  logic [WEIGHT_BITS-1:0] w_rd;

  always_ff @(posedge clk) begin
    if (cmd.clear_en) begin
      wmem[clr_addr] <= '0;
    end else if (cmd.load_en && s_tvalid && in_range) begin
      wmem[{vlo, vhi}] <= WEIGHT_BITS'(edge_weight);
    end
    w_rd <= wmem[{plo, phi}];
  end

  // key memory
  logic [KW-1:0]           kmem [2**VB];
  logic [KW-1:0]           k_rd;
  logic [MAX_VERTICES-1:0] key_valid;
  logic [MAX_VERTICES-1:0] visited;
  logic [KW-1:0]           k_cur, k_new;
  logic                    relax_en;

  assign k_cur = key_valid[stg_j] ? k_rd : KEY_UNREACHED;
  assign k_new = ((w_rd != '0) && (k_cur > KW'(w_rd))) ? KW'(w_rd) : k_cur;
  assign relax_en = stg_valid && !visited[stg_j];

  always_ff @(posedge clk) begin
    if (relax_en) begin
      kmem[stg_j] <= k_new;
    end
    k_rd <= kmem[jv];
  end

  // round state
  logic                  found;
  logic [KW-1:0]         best;
  logic [VB-1:0]         best_idx;
  logic [TOTAL_BITS-1:0] sum;
  logic                  cut;
  logic [SW-1:0]         sum_ext;

  assign sum_ext = SW'(sum) + SW'(best);

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
      key_valid <= '0;
      visited   <= '0;
      found     <= 1'b0;
      scan_j    <= '0;
    end else begin
      stg_valid <= cmd.scan_issue;
      if (cmd.scan_issue) begin
        stg_j  <= jv;
        scan_j <= scan_j + NW'(1);
      end
      if (relax_en) begin
        key_valid[stg_j] <= 1'b1;
        if (!found || k_new < best) begin
          found    <= 1'b1;
          best     <= k_new;
          best_idx <= stg_j;
        end
      end
      if (cmd.run_init) begin
        visited    <= MAX_VERTICES'(1);
        key_valid  <= '0;
        found      <= 1'b0;
        scan_j     <= '0;
        pick_idx   <= '0;
        sum        <= '0;
        cut        <= 1'b0;
      end
      if (cmd.pick) begin
        if (found && best == KEY_UNREACHED) begin
          cut <= 1'b1;
        end else if (found) begin
          visited[best_idx] <= 1'b1;
          pick_idx <= best_idx;
          sum      <= (sum_ext > SW'({TOTAL_BITS{1'b1}})) ? '1 : TOTAL_BITS'(sum_ext);
          found    <= 1'b0;
          scan_j   <= '0;
        end
      end
    end
  end

  // result register
  logic [TOTAL_BITS-1:0] total_weight;
  logic                  disconnected;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (cmd.out_load) begin
      total_weight <= sum;
      disconnected <= cut;
    end
  end

  assign m_tdata = M_DATA_BITS'(total_weight);
  assign m_tuser = disconnected;

  assign st.clear_last  = (clr_addr == ADDR_LAST);
  assign st.last_accept = cmd.load_en && s_tvalid && s_tlast;
  assign st.scan_end    = (scan_j == n_eff - NW'(1));
  assign st.run_done    = !found || (best == KEY_UNREACHED);
  assign st.out_free    = !m_tvalid || m_tready;

endmodule

FILE: sv/prim_mst_total_weight_top.sv
// ----------------------------------------------------------------------------
// prim_mst_total_weight_top
// Minimum spanning tree total weight by dense Prim over loaded edges.
// ----------------------------------------------------------------------------
// channel   dir  payload
// s_*       in   tdata: first_vertex, second_vertex, edge_weight; tlast: last_edge
// m_*       out  tdata: total_weight; tuser: disconnected
// cfg_*     in   vertex_count write
//
// Edges load at one per cycle while s_tready is high. The last edge starts Prim:
// each round scans n vertices through the weight memory read port. Then the
// result is handed to the output register and the weight memory is swept clear,
// all 2^(2*clog2(MAX_VERTICES)) entries (4096 by default), also after reset;
// input is stalled during compute and sweep, and while a finished result waits
// for the output register to free up.
// ----------------------------------------------------------------------------
module prim_mst_total_weight_top #(
  parameter int MAX_VERTICES = pmtw_pkg::MAX_VERTICES_DEF,
  parameter int WEIGHT_BITS  = pmtw_pkg::WEIGHT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [pmtw_pkg::COUNT_CFG_BITS-1:0] cfg_wdata,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // first_vertex[5:0], second_vertex[11:6], edge_weight[27:12], zero pad
  input  logic [pmtw_pkg::S_DATA_BITS-1:0]    s_tdata,
  input  logic                                s_tlast,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // total_weight[21:0], zero pad
  output logic [pmtw_pkg::M_DATA_BITS-1:0]    m_tdata,
  // disconnected[0]
  output logic                                m_tuser
);
  import pmtw_pkg::*;

  cmd_t  cmd;
  stat_t st;

  pmtw_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .st  (st),
    .cmd (cmd)
  );

  pmtw_dp #(
    .MAX_VERTICES (MAX_VERTICES),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  assign s_tready = cmd.load_en;

`include "prim_mst_total_weight_top_assert.svh"

  `PMTW_ASSERT_NEXT(a_last_stalls, clk, rst, s_tvalid && s_tready && s_tlast, !s_tready)
  `PMTW_ASSERT_NOW(a_out_only_when_free, clk, rst, cmd.out_load, !m_tvalid || m_tready)
  `PMTW_ASSERT_NEXT(a_result_raises_valid, clk, rst, cmd.out_load, m_tvalid)
  `PMTW_ASSERT_NOW(a_no_load_during_clear, clk, rst, cmd.clear_en, !s_tready)

endmodule

FILE: tb/prim_mst_total_weight_top_tb.sv
// ----------------------------------------------------------------------------
// prim_mst_total_weight_top_tb
// Drives directed and random edge lists into the spanning tree block, predicts
// each total weight and disconnected flag with a dense Prim search, and checks results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class mst_scoreboard;
  int unsigned vcount;
  logic [15:0] adj [64][64];
  logic [21:0] exp_total [$];
  logic        exp_cut [$];
  int unsigned errors;

  function new();
    vcount = 1;
    errors = 0;
    foreach (adj[i, j]) adj[i][j] = '0;
  endfunction

  function void set_count(logic [6:0] v);
    vcount = (v == 0) ? 1 : (v > 64 ? 64 : v);
  endfunction

  function void note_edge(logic [5:0] a, logic [5:0] b, logic [15:0] w, logic last);
    bit visited [64];
    logic [16:0] key [64];
    int unsigned pick;
    bit found;
    bit cut;
    longint unsigned sum;
    if (a < vcount && b < vcount) begin
      adj[a][b] = w;
      adj[b][a] = w;
    end
    if (!last) return;
    for (int i = 0; i < 64; i++) begin
      visited[i] = 0;
      key[i] = '1;
    end
    key[0] = 0;
    sum = 0;
    cut = 0;
    for (int r = 0; r < vcount; r++) begin
      found = 0;
      pick = 0;
      for (int i = 0; i < vcount; i++)
        if (!visited[i] && (!found || key[i] < key[pick])) begin
          pick = i;
          found = 1;
        end
      if (!found) break;
      if (key[pick] == 17'h1ffff) begin
        cut = 1;
        break;
      end
      visited[pick] = 1;
      sum += key[pick];
      for (int j = 0; j < vcount; j++)
        if (adj[pick][j] != 0 && !visited[j] && key[j] > adj[pick][j])
          key[j] = adj[pick][j];
    end
    exp_total.push_back(sum > 22'h3fffff ? 22'h3fffff : sum[21:0]);
    exp_cut.push_back(cut);
    foreach (adj[i, j]) adj[i][j] = '0;
  endfunction

  task report(string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  task check_result(logic [21:0] total, logic cut);
    logic [21:0] et;
    logic ec;
    if (exp_total.size() == 0) begin
      report($sformatf("unexpected result total=%0d", total));
      return;
    end
    et = exp_total.pop_front();
    ec = exp_cut.pop_front();
    if (total !== et) report($sformatf("total %0d, want %0d", total, et));
    if (cut !== ec) report($sformatf("disconnected %0b, want %0b", cut, ec));
  endtask
endclass

module prim_mst_total_weight_top_tb;
  import pmtw_pkg::*;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [6:0]  cfg_wdata;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;
  logic        m_tuser;

  mst_scoreboard sb;
  int unsigned   hold_off;
  bit            drive_done;

  prim_mst_total_weight_top u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #400ms;
    $display("prim_mst_total_weight_top_tb failed");
    $finish;
  end

  task send_edge(logic [5:0] a, logic [5:0] b, logic [15:0] w, logic last, bit gaps);
    int unsigned gap;
    gap = gaps ? $urandom_range(0, 15) : 0;
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      s_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata  <= {4'b0, w, b, a};
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    sb.note_edge(a, b, w, last);
  endtask

  task write_count(logic [6:0] v);
    s_tvalid <= 0;
    while (sb.exp_total.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_we    <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.set_count(v);
  endtask

  task send_graph(int unsigned n, int unsigned edges, bit gaps);
    logic [5:0] a, b;
    logic [15:0] w;
    for (int e = 0; e < edges; e++) begin
      if ($urandom_range(0, 15) == 0) begin
        a = 6'($urandom);
        b = 6'($urandom);
      end else begin
        a = 6'($urandom_range(0, n - 1));
        b = (e < n - 1 && $urandom_range(0, 1)) ? 6'(e + 1) : 6'($urandom_range(0, n - 1));
      end
      case ($urandom_range(0, 9))
        0: w = 16'h0000;
        1: w = 16'hffff;
        2: w = 16'($urandom_range(1, 4));
        default: w = 16'($urandom);
      endcase
      send_edge(a, b, w, e == edges - 1, gaps);
    end
  endtask

  initial begin
    int unsigned n;
    sb = new();
    rst = 1;
    cfg_we = 0;
    cfg_wdata = 0;
    s_tvalid = 0;
    s_tdata = 0;
    s_tlast = 0;
    hold_off = 0;
    drive_done = 0;
    repeat (2) @(posedge clk);
    rst <= 0;

    // directed
    send_edge(0, 0, 16'h1234, 1, 0);
    write_count(7'd0);
    send_edge(0, 0, 0, 1, 0);
    write_count(7'd127);
    send_edge(6'd63, 6'd0, 16'hffff, 0, 0);
    send_edge(6'd0, 6'd63, 16'h0001, 0, 0);
    send_edge(6'd5, 6'd5, 16'h0007, 1, 0);
    write_count(7'd4);
    send_edge(0, 1, 16'hffff, 0, 0);
    send_edge(1, 2, 16'hffff, 0, 0);
    send_edge(2, 3, 16'hffff, 0, 0);
    send_edge(0, 3, 16'h8000, 0, 0);
    send_edge(0, 2, 16'h0005, 0, 0);
    send_edge(0, 2, 16'h0000, 0, 0);
    send_edge(6'd4, 6'd1, 16'h0001, 0, 0);
    send_edge(1, 3, 16'h0002, 0, 0);
    send_edge(1, 2, 16'h0002, 1, 0);
    write_count(7'd3);
    send_edge(0, 1, 16'h0003, 0, 0);
    send_edge(1, 2, 16'h0003, 0, 0);
    send_edge(0, 2, 16'h0003, 0, 0);
    send_edge(6'd42, 6'd21, 16'haaaa, 1, 0);
    write_count(7'd64);
    send_edge(6'd63, 6'd62, 16'h5555, 1, 0);

    // long receiver stall while edges keep coming
    write_count(7'd2);
    hold_off = 20000;
    for (int k = 0; k < 20; k++) send_edge(0, 1, 16'($urandom), 1, 0);

    // random
    for (int p = 0; p < 16; p++) begin
      case (p % 4)
        0: n = $urandom_range(1, 8);
        1: n = $urandom_range(2, 16);
        2: n = (p == 6) ? 64 : $urandom_range(1, 12);
        default: n = $urandom_range(1, 127);
      endcase
      write_count(n[6:0]);
      if (n > 64) n = 64;
      for (int g = 0; g < 11; g++)
        send_graph(n, $urandom_range(1, n < 10 ? 2 * n + 2 : 24), p % 3 != 0);
    end

    s_tvalid <= 0;
    drive_done = 1;
    while (sb.exp_total.size() != 0) @(posedge clk);
    repeat (20000) @(posedge clk);
    if (sb.errors == 0 && sb.exp_total.size() == 0)
      $display("prim_mst_total_weight_top_tb passed");
    else
      $display("prim_mst_total_weight_top_tb failed");
    $finish;
  end

  initial begin
    int unsigned gap;
    m_tready = 0;
    @(negedge rst);
    forever begin
      if (hold_off != 0) begin
        m_tready <= 0;
        repeat (hold_off) @(posedge clk);
        hold_off = 0;
      end
      gap = $urandom_range(0, 15);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
        m_tready <= 0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1;
      do @(posedge clk); while (!m_tvalid);
      sb.check_result(m_tdata[21:0], m_tuser);
    end
  end
endmodule
